// ----- rtl/core/acs_pkg.sv -----
package acs_pkg;

  // Field widths
  localparam int ADDR_W = 12;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int REQ_W  = 2;
  localparam int FMT_W  = 2;
  localparam int OPC_W  = 4;

  // Byte memory split into an even bank and an odd bank
  localparam int MEM_DEPTH  = 4096;
  localparam int BANK_DEPTH = MEM_DEPTH / 2;
  localparam int BANK_AW    = ADDR_W - 1;

  // Request types
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_HALT = 4'd0;
  localparam logic [OPC_W-1:0] OP_NOT  = 4'd1;
  localparam logic [OPC_W-1:0] OP_SHL  = 4'd2;
  localparam logic [OPC_W-1:0] OP_SHR  = 4'd3;
  localparam logic [OPC_W-1:0] OP_INC  = 4'd4;
  localparam logic [OPC_W-1:0] OP_DEC  = 4'd5;
  localparam logic [OPC_W-1:0] OP_JMP  = 4'd6;
  localparam logic [OPC_W-1:0] OP_JAZ  = 4'd7;
  localparam logic [OPC_W-1:0] OP_LDA  = 4'd8;
  localparam logic [OPC_W-1:0] OP_STA  = 4'd9;
  localparam logic [OPC_W-1:0] OP_ADD  = 4'd10;
  localparam logic [OPC_W-1:0] OP_AND  = 4'd11;
  localparam logic [OPC_W-1:0] OP_ORR  = 4'd12;
  localparam logic [OPC_W-1:0] OP_XOR  = 4'd13;
  localparam logic [OPC_W-1:0] OP_OUT  = 4'd14;
  localparam logic [OPC_W-1:0] OP_INP  = 4'd15;

  // Largest valid format code for out and inp
  localparam logic [FMT_W-1:0] FMT_MAX = 2'd2;

  // Execute unit outcome
  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic              halt;
    logic              jump;
    logic              out_en;
    logic              in_used;
  } acs_alu_res_t;

endpackage

// ----- rtl/core/acs_ram.sv -----
module acs_ram import acs_pkg::*; #(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = BANK_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/acs_alu.sv -----
module acs_alu import acs_pkg::*; (
  input  logic [OPC_W-1:0]  opcode,
  input  logic [ADDR_W-1:0] arg,
  input  logic [WORD_W-1:0] acc,
  input  logic [WORD_W-1:0] mem_word,
  input  logic [WORD_W-1:0] in_value,
  output acs_alu_res_t      res
);

  logic               big_shift;
  logic               fmt_ok;
  logic signed [WORD_W-1:0] acc_s;

  assign big_shift = (arg[ADDR_W-1:4] != '0);
  assign fmt_ok    = (arg[ADDR_W-1:FMT_W] == '0) && (arg[FMT_W-1:0] <= FMT_MAX);
  assign acc_s     = $signed(acc);

  // Decode the opcode into the new accumulator and side effects
  always_comb begin
    res = '0;
    res.acc = acc;
    case (opcode)
      OP_HALT: res.halt = 1'b1;
      OP_NOT:  res.acc = ~acc;
      OP_SHL:  res.acc = big_shift ? '0 : (acc << arg[3:0]);
      OP_SHR:  res.acc = big_shift ? {WORD_W{acc[WORD_W-1]}} : WORD_W'(acc_s >>> arg[3:0]);
      OP_INC:  res.acc = acc + WORD_W'(1);
      OP_DEC:  res.acc = acc - WORD_W'(1);
      OP_JMP:  res.jump = 1'b1;
      OP_JAZ:  res.jump = (acc == '0);
      OP_LDA:  res.acc = mem_word;
      OP_STA:  res.acc = acc;
      OP_ADD:  res.acc = acc + mem_word;
      OP_AND:  res.acc = acc & mem_word;
      OP_ORR:  res.acc = acc | mem_word;
      OP_XOR:  res.acc = acc ^ mem_word;
      OP_OUT:  res.out_en = fmt_ok;
      OP_INP: begin
        if (fmt_ok) begin
          res.in_used = 1'b1;
          res.acc = in_value;
        end
      end
      default: res.acc = acc;
    endcase
  end

endmodule

// ----- rtl/core/accumulator_cpu_step.sv -----
// 16-bit accumulator processor with a 4096-byte memory.
// Request channel (in_valid / in_stall) carries req_type, mem_addr, mem_data
// and in_value; a request is taken when in_valid is high and in_stall low.
// Result channel (res_valid / res_stall) returns one result per request, in
// order, from an output register.
// A step request passes after acceptance through instruction fetch, operand
// read and execute/writeback, each at most one access to the byte memory,
// held as an even and an odd bank so one 16-bit word is read per cycle. A
// read request passes through fetch and operand read, a write or unused
// request through fetch only. The next request is taken in the cycle the
// current one retires, so a request is not started before the last is done.
// After reset the memory is cleared in a pass over all 2048 bank addresses,
// during which in_stall is high; accumulator, PC and halt flag reset to zero.
// When the receiver stalls, the result stays in the output register and the
// next request finishes all but its retire cycle, then waits with in_stall
// high until the output register frees up.
module accumulator_cpu_step import acs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [ADDR_W-1:0] mem_addr,
  input  logic [BYTE_W-1:0] mem_data,
  input  logic [WORD_W-1:0] in_value,
  output logic              res_valid,
  input  logic              res_stall,
  output logic              out_valid,
  output logic [FMT_W-1:0]  out_format,
  output logic [WORD_W-1:0] out_value,
  output logic              in_used,
  output logic [WORD_W-1:0] accumulator,
  output logic [ADDR_W-1:0] prog_counter,
  output logic              halted,
  output logic [BYTE_W-1:0] read_byte
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FETCH  = 3'd2;
  localparam logic [2:0] ST_DECODE = 3'd3;
  localparam logic [2:0] ST_EXEC   = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  logic [BANK_AW-1:0] clr_cnt;

  // Request register
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;
  logic [BYTE_W-1:0] data_q;
  logic [WORD_W-1:0] inval_q;

  // Architectural state
  logic [WORD_W-1:0] acc_q;
  logic [ADDR_W-1:0] pc_q;
  logic              halt_q;

  logic [WORD_W-1:0] instr_q;
  logic              align_q;

  // Bank ports
  logic               ev_we, od_we, ev_re, od_re;
  logic [BANK_AW-1:0] ev_waddr, od_waddr, ev_raddr, od_raddr;
  logic [BYTE_W-1:0]  ev_wdata, od_wdata, ev_rdata, od_rdata;

  logic [ADDR_W-1:0]  rd_addr;
  logic [BANK_AW-1:0] rd_half;
  logic [WORD_W-1:0]  word_rd;
  logic [BANK_AW-1:0] sta_half;

  logic               out_free;
  logic               finish;
  logic               accept;

  logic [ADDR_W-1:0]  pc_adv;
  logic [ADDR_W-1:0]  pc_next;
  logic [WORD_W-1:0]  acc_next;
  logic               halt_next;
  acs_alu_res_t       alu_res;

  // Handshake
  assign out_free = !res_valid || !res_stall;
  assign accept   = in_valid && !in_stall;
  assign in_stall = !((state == ST_IDLE) || finish);

  always_comb begin
    case (state)
      ST_FETCH:  finish = (req_q != REQ_STEP) && (req_q != REQ_READ) && out_free;
      ST_DECODE: finish = (req_q == REQ_READ) && out_free;
      ST_EXEC:   finish = out_free;
      default:   finish = 1'b0;
    endcase
  end

  // Sequence the request through fetch, decode and execute
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  state_next = (&clr_cnt) ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_next = accept ? ST_FETCH : ST_IDLE;
      ST_FETCH: begin
        if (req_q == REQ_STEP || req_q == REQ_READ) begin
          state_next = ST_DECODE;
        end else if (finish) begin
          state_next = accept ? ST_FETCH : ST_IDLE;
        end
      end
      ST_DECODE: begin
        if (req_q == REQ_STEP) begin
          state_next = ST_EXEC;
        end else if (finish) begin
          state_next = accept ? ST_FETCH : ST_IDLE;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_next = accept ? ST_FETCH : ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + BANK_AW'(1);
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req_type;
      addr_q  <= mem_addr;
      data_q  <= mem_data;
      inval_q <= in_value;
    end
  end

  // Assemble the word from the two banks; align_q marks an odd start
  assign word_rd = align_q ? {ev_rdata, od_rdata} : {od_rdata, ev_rdata};

  // Pick the word address to read this cycle
  always_comb begin
    case (state)
      ST_FETCH: rd_addr = (req_q == REQ_STEP) ? pc_q : addr_q;
      default:  rd_addr = word_rd[ADDR_W-1:0];
    endcase
  end
  assign rd_half  = rd_addr[ADDR_W-1:1];
  assign sta_half = instr_q[ADDR_W-1:1];

  // Drive the banks: clear sweep, reads, byte and word writes
  always_comb begin
    ev_we    = 1'b0;
    od_we    = 1'b0;
    ev_waddr = clr_cnt;
    od_waddr = clr_cnt;
    ev_wdata = '0;
    od_wdata = '0;
    ev_re    = 1'b0;
    od_re    = 1'b0;
    ev_raddr = rd_addr[0] ? rd_half + BANK_AW'(1) : rd_half;
    od_raddr = rd_half;
    case (state)
      ST_CLEAR: begin
        ev_we = 1'b1;
        od_we = 1'b1;
      end
      ST_FETCH: begin
        if (req_q == REQ_STEP || req_q == REQ_READ) begin
          ev_re = 1'b1;
          od_re = 1'b1;
        end else if (req_q == REQ_WRITE && finish) begin
          ev_we    = !addr_q[0];
          od_we    = addr_q[0];
          ev_waddr = addr_q[ADDR_W-1:1];
          od_waddr = addr_q[ADDR_W-1:1];
          ev_wdata = data_q;
          od_wdata = data_q;
        end
      end
      ST_DECODE: begin
        if (req_q == REQ_STEP) begin
          ev_re = 1'b1;
          od_re = 1'b1;
        end
      end
      ST_EXEC: begin
        if (instr_q[WORD_W-1:ADDR_W] == OP_STA && finish) begin
          ev_we    = 1'b1;
          od_we    = 1'b1;
          ev_waddr = instr_q[0] ? sta_half + BANK_AW'(1) : sta_half;
          od_waddr = sta_half;
          ev_wdata = instr_q[0] ? acc_q[WORD_W-1:BYTE_W] : acc_q[BYTE_W-1:0];
          od_wdata = instr_q[0] ? acc_q[BYTE_W-1:0] : acc_q[WORD_W-1:BYTE_W];
        end
      end
      default: ;
    endcase
  end

  acs_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_even (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .re    (ev_re),
    .raddr (ev_raddr),
    .rdata (ev_rdata)
  );

  acs_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_odd (
    .clk   (clk),
    .we    (od_we),
    .waddr (od_waddr),
    .wdata (od_wdata),
    .re    (od_re),
    .raddr (od_raddr),
    .rdata (od_rdata)
  );

  // Track alignment of the word in flight and latch the instruction
  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      align_q <= rd_addr[0];
    end else if (state == ST_DECODE && req_q == REQ_STEP) begin
      align_q <= rd_addr[0];
      instr_q <= word_rd;
    end
  end

  acs_alu u_alu (
    .opcode   (instr_q[WORD_W-1:ADDR_W]),
    .arg      (instr_q[ADDR_W-1:0]),
    .acc      (acc_q),
    .mem_word (word_rd),
    .in_value (inval_q),
    .res      (alu_res)
  );

  // Refuse a PC advance past the top of memory
  assign pc_adv    = (&pc_q[ADDR_W-1:1]) ? pc_q : pc_q + ADDR_W'(2);
  assign pc_next   = alu_res.jump ? instr_q[ADDR_W-1:0] : pc_adv;
  assign acc_next  = alu_res.acc;
  assign halt_next = halt_q | alu_res.halt;

  // Commit architectural state when a step retires
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_q  <= '0;
      pc_q   <= '0;
      halt_q <= 1'b0;
    end else if (state == ST_EXEC && finish) begin
      acc_q  <= acc_next;
      pc_q   <= pc_next;
      halt_q <= halt_next;
    end
  end

  // Load the output register on retire, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (state == ST_EXEC) begin
        out_valid    <= alu_res.out_en;
        out_format   <= alu_res.out_en ? instr_q[FMT_W-1:0] : '0;
        out_value    <= alu_res.out_en ? acc_q : '0;
        in_used      <= alu_res.in_used;
        accumulator  <= acc_next;
        prog_counter <= pc_next;
        halted       <= halt_next;
        read_byte    <= '0;
      end else begin
        out_valid    <= 1'b0;
        out_format   <= '0;
        out_value    <= '0;
        in_used      <= 1'b0;
        accumulator  <= acc_q;
        prog_counter <= pc_q;
        halted       <= halt_q;
        read_byte    <= (state == ST_DECODE) ? word_rd[BYTE_W-1:0] : '0;
      end
    end
  end

  // No request is taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    accept |-> state != ST_CLEAR)
    else $error("request accepted during memory clear");

  // A request taken on retire starts its fetch next cycle
  a_accept_to_fetch: assert property (@(posedge clk) disable iff (rst)
    (finish && accept) |=> state == ST_FETCH)
    else $error("accepted request did not enter fetch");

  // A new result only appears after a retire
  a_result_from_retire: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(finish))
    else $error("result raised without a retire");

  // The halt flag stays set until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(halt_q))
    else $error("halt flag cleared without reset");

endmodule
